[src/ppbg_pkg.sv]
// Shared constants and types for the burst pulse generator.
package ppbg_pkg;

   // Channel count and derived widths.
   localparam int CHANNELS = 3;
   localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SHOWN_CH = (CHANNELS < 3) ? CHANNELS : 3;

   // Register reset values.
   localparam logic [15:0] PERIOD_TICKS_RESET = 16'd46874;
   localparam logic [15:0] PERIOD_US_RESET    = 16'd5000;
   localparam logic [15:0] COMPARE_RESET      = PERIOD_TICKS_RESET >> 1;

   // Register indexes, decoded from the word address.
   localparam logic REG_PERIOD_TICKS = 1'b0;
   localparam logic REG_PERIOD_US    = 1'b1;

   // Request kinds and the broadcast channel select.
   localparam logic       REQ_TICK  = 1'b0;
   localparam logic       REQ_START = 1'b1;
   localparam logic [1:0] SEL_ALL   = 2'd3;

   // Divider: one quotient bit per step.
   localparam int          DIV_STEPS = 16;
   localparam int          DIV_CNT_W = $clog2(DIV_STEPS);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

   // Handshake between the sequencer and the divider.
   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [15:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [15:0] quotient;
   } div_rsp_type;

endpackage

[src/pwm_pulse_burst_generator.sv]
// Top level of the three-channel burst pulse generator with its sequencer.
//
// Every request transaction gives exactly one response transaction. A tick
// walks the channels one per cycle through a single shared counter update
// and then gives its response. A start runs the width scaling through one
// 16x16 multiply and then the bit-serial divider, sixteen steps plus hand-off,
// before it loads the channels; a rejected start goes straight to its response.
// The block takes no new request while one is being worked on. A response
// that is not yet taken does not hold off the next request; the sequencer
// waits only when it has a new response and the output register is full.
module pwm_pulse_burst_generator
   import ppbg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // [1:0] channel_select, [17:2] pulse_count,
                                   // [33:18] pulse_width_us, [39:34] zero
   input  logic        req_tuser,  // [0] req_type
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // [2:0] pulse_levels, [5:3] busy_mask, [7:6] zero
   output logic        rsp_tuser,  // [0] accepted
   // Register port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_TICK   = 6'b000010,
      S_MUL    = 6'b000100,
      S_DIV    = 6'b001000,
      S_LOAD   = 6'b010000,
      S_RESULT = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [15:0] period_ticks_ff, period_ticks_in;
   logic [15:0] period_us_ff, period_us_in;

   // Captured request.
   logic [1:0]  sel_ff, sel_in;
   logic [15:0] count_ff, count_in;
   logic [15:0] width_ff, width_in;
   logic        acc_ff, acc_in;

   // Per-channel state.
   logic [15:0] counter_ff [CHANNELS];
   logic [15:0] counter_in [CHANNELS];
   logic [15:0] compare_ff [CHANNELS];
   logic [15:0] compare_in [CHANNELS];
   logic [15:0] done_ff    [CHANNELS];
   logic [15:0] done_in    [CHANNELS];
   logic [15:0] last_ff    [CHANNELS];
   logic [15:0] last_in    [CHANNELS];
   logic [CHANNELS-1:0] running_ff, running_in;
   logic [CHANNELS-1:0] level_ff, level_in;

   // Sequencer working registers.
   logic [CH_W-1:0] ch_ff, ch_in;
   logic [31:0]     product_ff, product_in;
   logic            div_start_ff, div_start_in;

   // Response register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_acc_ff, rsp_acc_in;
   logic [2:0] rsp_levels_ff, rsp_levels_in;
   logic [2:0] rsp_busy_ff, rsp_busy_in;

   // Shared channel update unit.
   logic [15:0] cur_cnt, cur_cmp, cur_done, cur_last;
   logic        cur_run;
   logic [15:0] tk_cnt, tk_done;
   logic        tk_run, tk_lvl, tk_check;

   // Request fields and decode.
   logic [1:0]  req_sel;
   logic [15:0] req_count, req_width;
   logic        req_reject;
   logic        req_accept, rsp_accept, rsp_free;
   logic        csr_write;
   logic [15:0] cmp_value;
   logic [2:0]  show_levels, show_busy;

   div_req_type div_req;
   div_rsp_type div_rsp;

   ppbg_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign div_req.start    = div_start_ff;
   assign div_req.dividend = product_ff;
   assign div_req.divisor  = period_us_ff;

   // Handshakes.
   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = rsp_valid_ff && rsp_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   assign req_sel   = req_tdata[1:0];
   assign req_count = req_tdata[17:2];
   assign req_width = req_tdata[33:18];

   // A start is refused for a zero count, a zero or too long width, or a
   // single channel that does not exist.
   assign req_reject = (req_count == 16'd0) || (req_width == 16'd0) ||
                       (req_width >= period_us_ff) ||
                       ((req_sel != SEL_ALL) && (32'(req_sel) >= CHANNELS));

   // Register port: writes on the access phase, reads are combinational.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      period_ticks_in = period_ticks_ff;
      period_us_in    = period_us_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            REG_PERIOD_TICKS: period_ticks_in = csr_pwdata[15:0];
            REG_PERIOD_US:    period_us_in    = csr_pwdata[15:0];
            default:          period_ticks_in = period_ticks_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_PERIOD_TICKS: csr_prdata = {16'd0, period_ticks_ff};
         REG_PERIOD_US:    csr_prdata = {16'd0, period_us_ff};
         default:          csr_prdata = 32'd0;
      endcase
   end

   // The channel picked by the sequencer goes through one tick.
   assign cur_cnt  = counter_ff[ch_ff];
   assign cur_cmp  = compare_ff[ch_ff];
   assign cur_done = done_ff[ch_ff];
   assign cur_last = last_ff[ch_ff];
   assign cur_run  = running_ff[ch_ff];

   always_comb begin
      tk_cnt   = cur_cnt;
      tk_done  = cur_done;
      tk_run   = cur_run;
      tk_lvl   = level_ff[ch_ff];
      tk_check = 1'b0;
      if (cur_run) begin
         tk_check = 1'b1;
         if (cur_cnt >= period_ticks_ff) begin
            // Period end: wrap, drop the output and count one pulse.
            tk_cnt  = 16'd0;
            tk_lvl  = 1'b0;
            tk_done = cur_done + 16'd1;
            if (cur_done >= cur_last) begin
               tk_run   = 1'b0;
               tk_check = 1'b0;
            end
         end else begin
            tk_cnt = cur_cnt + 16'd1;
         end
         if (tk_check && (tk_cnt == cur_cmp)) begin
            tk_lvl = 1'b1;
         end
      end
   end

   // Compare value from the scaled width.
   assign cmp_value = period_ticks_ff - div_rsp.quotient;

   // Output masks show the first three channels only.
   always_comb begin
      show_levels = 3'b000;
      show_busy   = 3'b000;
      for (int i = 0; i < SHOWN_CH; i++) begin
         show_levels[i] = level_ff[i];
         show_busy[i]   = running_ff[i];
      end
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      sel_in        = sel_ff;
      count_in      = count_ff;
      width_in      = width_ff;
      acc_in        = acc_ff;
      ch_in         = ch_ff;
      product_in    = product_ff;
      div_start_in  = 1'b0;
      running_in    = running_ff;
      level_in      = level_ff;
      for (int i = 0; i < CHANNELS; i++) begin
         counter_in[i] = counter_ff[i];
         compare_in[i] = compare_ff[i];
         done_in[i]    = done_ff[i];
         last_in[i]    = last_ff[i];
      end
      rsp_valid_in  = rsp_accept ? 1'b0 : rsp_valid_ff;
      rsp_acc_in    = rsp_acc_ff;
      rsp_levels_in = rsp_levels_ff;
      rsp_busy_in   = rsp_busy_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               sel_in   = req_sel;
               count_in = req_count;
               width_in = req_width;
               ch_in    = '0;
               if (req_tuser == REQ_TICK) begin
                  acc_in   = 1'b1;
                  state_in = S_TICK;
               end else if (req_reject) begin
                  acc_in   = 1'b0;
                  state_in = S_RESULT;
               end else begin
                  acc_in   = 1'b1;
                  state_in = S_MUL;
               end
            end
         end
         S_TICK: begin
            counter_in[ch_ff] = tk_cnt;
            done_in[ch_ff]    = tk_done;
            running_in[ch_ff] = tk_run;
            level_in[ch_ff]   = tk_lvl;
            if (ch_ff == CH_W'(CHANNELS - 1)) begin
               state_in = S_RESULT;
            end else begin
               ch_in = ch_ff + CH_W'(1);
            end
         end
         S_MUL: begin
            product_in   = width_ff * period_ticks_ff;
            div_start_in = 1'b1;
            state_in     = S_DIV;
         end
         S_DIV: begin
            if (div_rsp.done) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            // Start the named channels, overriding any running burst.
            for (int i = 0; i < CHANNELS; i++) begin
               if ((sel_ff == SEL_ALL) || (32'(sel_ff) == i)) begin
                  done_in[i]    = 16'd0;
                  last_in[i]    = count_ff - 16'd1;
                  compare_in[i] = cmp_value;
                  counter_in[i] = 16'd0;
                  level_in[i]   = 1'b0;
                  running_in[i] = 1'b1;
               end
            end
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_acc_in    = acc_ff;
               rsp_levels_in = show_levels;
               rsp_busy_in   = show_busy;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         period_ticks_ff <= PERIOD_TICKS_RESET;
         period_us_ff    <= PERIOD_US_RESET;
         running_ff      <= '0;
         level_ff        <= '0;
         div_start_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            counter_ff[i] <= 16'd0;
            compare_ff[i] <= COMPARE_RESET;
            done_ff[i]    <= 16'd0;
            last_ff[i]    <= 16'd0;
         end
      end else begin
         state_ff        <= state_in;
         period_ticks_ff <= period_ticks_in;
         period_us_ff    <= period_us_in;
         running_ff      <= running_in;
         level_ff        <= level_in;
         div_start_ff    <= div_start_in;
         rsp_valid_ff    <= rsp_valid_in;
         for (int i = 0; i < CHANNELS; i++) begin
            counter_ff[i] <= counter_in[i];
            compare_ff[i] <= compare_in[i];
            done_ff[i]    <= done_in[i];
            last_ff[i]    <= last_in[i];
         end
      end
      sel_ff        <= sel_in;
      count_ff      <= count_in;
      width_ff      <= width_in;
      acc_ff        <= acc_in;
      ch_ff         <= ch_in;
      product_ff    <= product_in;
      rsp_acc_ff    <= rsp_acc_in;
      rsp_levels_ff <= rsp_levels_in;
      rsp_busy_ff   <= rsp_busy_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_busy_ff, rsp_levels_ff};
   assign rsp_tuser  = rsp_acc_ff;

   // A channel output is only ever high while its burst runs.
   assert property (@(posedge clock) disable iff (reset)
      (level_ff & ~running_ff) == '0)
      else $error("channel output high on a stopped channel");

   // The scaled width never exceeds the period, since width is below period_us.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOAD) |-> (div_rsp.quotient <= period_ticks_ff))
      else $error("scaled width exceeds the period");

   // The channel walk never leaves the channel range.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TICK) |-> (32'(ch_ff) < CHANNELS))
      else $error("tick sequencer beyond the last channel");

   // A divide result arrives only while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_DIV))
      else $error("divider finished outside the divide phase");

endmodule

[src/ppbg_divider.sv]
// Iterative restoring divider, one quotient bit per clock cycle.
module ppbg_divider
   import ppbg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [15:0]          rem_ff, rem_in;
   logic [15:0]          dvd_ff, dvd_in;
   logic [15:0]          divisor_ff, divisor_in;
   logic [15:0]          quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [16:0]          trial;
   logic [16:0]          diff;

   // Trial subtraction of the divisor from the shifted partial remainder.
   assign trial = {rem_ff, dvd_ff[15]};
   assign diff  = trial - {1'b0, divisor_ff};

   // The quotient is known to fit in 16 bits, so the upper dividend half
   // already lies below the divisor and seeds the remainder.
   always_comb begin
      rem_in     = rem_ff;
      dvd_in     = dvd_ff;
      divisor_in = divisor_ff;
      quo_in     = quo_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (div_req.start) begin
         rem_in     = div_req.dividend[31:16];
         dvd_in     = div_req.dividend[15:0];
         divisor_in = div_req.divisor;
         cnt_in     = '0;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         if (!diff[16]) begin
            rem_in = diff[15:0];
            quo_in = {quo_ff[14:0], 1'b1};
         end else begin
            rem_in = trial[15:0];
            quo_in = {quo_ff[14:0], 1'b0};
         end
         dvd_in = {dvd_ff[14:0], 1'b0};
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff     <= rem_in;
      dvd_ff     <= dvd_in;
      divisor_ff <= divisor_in;
      quo_ff     <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule
